>>> hw/rtl/lap_pkg.sv
// Shared types, constants and arithmetic helpers for the allpass phaser.
package lap_pkg;

    localparam int SIG_W  = 24;
    localparam int MA_W   = 25;
    localparam int MB_W   = 18;
    localparam int PROD_W = 43;
    localparam int RND_W  = 28;
    localparam int STG_W  = 5;
    localparam int CNT_W  = 5;
    localparam int DIV_STEPS = 31;

    localparam logic [15:0] FREQ_CLAMP = 16'd32112;
    localparam logic [15:0] SIN_A = 16'd51472;
    localparam logic [15:0] SIN_B = 16'd21024;
    localparam logic [15:0] SIN_C = 16'd2320;

    localparam logic [2:0] REG_PHASE_STEP    = 3'd0;
    localparam logic [2:0] REG_FREQ_LOW      = 3'd1;
    localparam logic [2:0] REG_FREQ_SPAN     = 3'd2;
    localparam logic [2:0] REG_FEEDBACK_GAIN = 3'd3;
    localparam logic [2:0] REG_WET_GAIN      = 3'd4;
    localparam logic [2:0] REG_DRY_GAIN      = 3'd5;
    localparam logic [2:0] REG_STAGES_USED   = 3'd6;
    localparam logic [2:0] REG_CHANNELS_USED = 3'd7;

    localparam logic [1:0] SEL_LFO = 2'd0;
    localparam logic [1:0] SEL_SN  = 2'd1;
    localparam logic [1:0] SEL_CS  = 2'd2;

    typedef enum logic [4:0] {
        OP_NOP, OP_LOAD, OP_SX, OP_M1, OP_M2, OP_M3, OP_M4, OP_SY, OP_FREQ,
        OP_DINIT, OP_DSTEP, OP_DEND, OP_FB, OP_V, OP_SA, OP_SYST, OP_SB,
        OP_SW, OP_FBW, OP_MIX, OP_OUT
    } op_t;

    typedef enum logic [4:0] {
        S_IDLE, S_SX, S_M1, S_M2, S_M3, S_M4, S_SY, S_FREQ, S_DINIT, S_DSTEP,
        S_DEND, S_FB, S_V, S_SA, S_SYST, S_SB, S_SW, S_FBW, S_MIX, S_OUT
    } state_t;

    typedef struct packed {
        op_t              op;
        logic [1:0]       sel;
        logic [STG_W-1:0] stage;
    } cmd_t;

    typedef struct packed {
        logic frame_start;
        logic out_free;
    } status_t;

    typedef struct packed {
        logic [31:0]        phase_step;
        logic [14:0]        freq_low;
        logic [14:0]        freq_span;
        logic signed [15:0] feedback_gain;
        logic [15:0]        wet_gain;
        logic [15:0]        dry_gain;
        logic [3:0]         stages_used;
        logic [1:0]         channels_used;
    } cfg_t;

    function automatic logic signed [RND_W-1:0] rnd15(input logic signed [PROD_W-1:0] p);
        logic signed [PROD_W-1:0] t;
        t = p + PROD_W'(16384);
        return t[PROD_W-1:15];
    endfunction

    function automatic logic signed [SIG_W-1:0] sat24(input logic signed [RND_W:0] v);
        logic signed [SIG_W-1:0] r;
        if (v > $signed((RND_W+1)'(24'h7FFFFF)))
            r = 24'sh7FFFFF;
        else if (v < -$signed((RND_W+1)'(24'h800000)))
            r = 24'sh800000;
        else
            r = v[SIG_W-1:0];
        return r;
    endfunction

endpackage

>>> hw/rtl/lap_ctrl.sv
// Sequencer for the phaser: frame setup, divider steps, stage loop, output.
module lap_ctrl #(
    parameter int MAX_STAGES = 8
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [3:0]          stages_used,
    input  lap_pkg::status_t    status,
    output lap_pkg::cmd_t       cmd
);

    lap_pkg::state_t state_reg, state_next;
    logic [1:0] sel_reg, sel_next;
    logic [lap_pkg::STG_W-1:0] stage_reg, stage_next;
    logic [lap_pkg::CNT_W-1:0] cnt_reg, cnt_next;
    logic [lap_pkg::STG_W-1:0] last_stage;
    logic [5:0] su_ext;

    always_comb
    begin
        su_ext = {2'b00, stages_used};
        if (su_ext == 6'd0)
            last_stage = '0;
        else if (su_ext > 6'(MAX_STAGES))
            last_stage = lap_pkg::STG_W'(MAX_STAGES - 1);
        else
            last_stage = lap_pkg::STG_W'(su_ext - 6'd1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= lap_pkg::S_IDLE;
            sel_reg   <= lap_pkg::SEL_LFO;
            stage_reg <= '0;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            sel_reg   <= sel_next;
            stage_reg <= stage_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        sel_next   = sel_reg;
        stage_next = stage_reg;
        cnt_next   = cnt_reg;
        unique case (state_reg)
            lap_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    sel_next   = lap_pkg::SEL_LFO;
                    stage_next = '0;
                    state_next = status.frame_start ? lap_pkg::S_SX : lap_pkg::S_FB;
                end
            end
            lap_pkg::S_SX: state_next = lap_pkg::S_M1;
            lap_pkg::S_M1: state_next = lap_pkg::S_M2;
            lap_pkg::S_M2: state_next = lap_pkg::S_M3;
            lap_pkg::S_M3: state_next = lap_pkg::S_M4;
            lap_pkg::S_M4: state_next = lap_pkg::S_SY;
            lap_pkg::S_SY:
            begin
                priority if (sel_reg == lap_pkg::SEL_LFO)
                    state_next = lap_pkg::S_FREQ;
                else if (sel_reg == lap_pkg::SEL_SN)
                begin
                    sel_next   = lap_pkg::SEL_CS;
                    state_next = lap_pkg::S_SX;
                end
                else
                    state_next = lap_pkg::S_DINIT;
            end
            lap_pkg::S_FREQ:
            begin
                sel_next   = lap_pkg::SEL_SN;
                state_next = lap_pkg::S_SX;
            end
            lap_pkg::S_DINIT:
            begin
                cnt_next   = '0;
                state_next = lap_pkg::S_DSTEP;
            end
            lap_pkg::S_DSTEP:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == lap_pkg::CNT_W'(lap_pkg::DIV_STEPS - 1))
                    state_next = lap_pkg::S_DEND;
            end
            lap_pkg::S_DEND: state_next = lap_pkg::S_FB;
            lap_pkg::S_FB:   state_next = lap_pkg::S_V;
            lap_pkg::S_V:    state_next = lap_pkg::S_SA;
            lap_pkg::S_SA:   state_next = lap_pkg::S_SYST;
            lap_pkg::S_SYST: state_next = lap_pkg::S_SB;
            lap_pkg::S_SB:   state_next = lap_pkg::S_SW;
            lap_pkg::S_SW:
            begin
                if (stage_reg == last_stage)
                    state_next = lap_pkg::S_FBW;
                else
                begin
                    stage_next = stage_reg + 1'b1;
                    state_next = lap_pkg::S_SA;
                end
            end
            lap_pkg::S_FBW: state_next = lap_pkg::S_MIX;
            lap_pkg::S_MIX: state_next = lap_pkg::S_OUT;
            lap_pkg::S_OUT:
            begin
                if (status.out_free)
                    state_next = lap_pkg::S_IDLE;
            end
            default: state_next = lap_pkg::S_IDLE;
        endcase
    end

    always_comb
    begin
        in_ready  = (state_reg == lap_pkg::S_IDLE);
        cmd.sel   = sel_reg;
        cmd.stage = stage_reg;
        unique case (state_reg)
            lap_pkg::S_IDLE:  cmd.op = in_valid ? lap_pkg::OP_LOAD : lap_pkg::OP_NOP;
            lap_pkg::S_SX:    cmd.op = lap_pkg::OP_SX;
            lap_pkg::S_M1:    cmd.op = lap_pkg::OP_M1;
            lap_pkg::S_M2:    cmd.op = lap_pkg::OP_M2;
            lap_pkg::S_M3:    cmd.op = lap_pkg::OP_M3;
            lap_pkg::S_M4:    cmd.op = lap_pkg::OP_M4;
            lap_pkg::S_SY:    cmd.op = lap_pkg::OP_SY;
            lap_pkg::S_FREQ:  cmd.op = lap_pkg::OP_FREQ;
            lap_pkg::S_DINIT: cmd.op = lap_pkg::OP_DINIT;
            lap_pkg::S_DSTEP: cmd.op = lap_pkg::OP_DSTEP;
            lap_pkg::S_DEND:  cmd.op = lap_pkg::OP_DEND;
            lap_pkg::S_FB:    cmd.op = lap_pkg::OP_FB;
            lap_pkg::S_V:     cmd.op = lap_pkg::OP_V;
            lap_pkg::S_SA:    cmd.op = lap_pkg::OP_SA;
            lap_pkg::S_SYST:  cmd.op = lap_pkg::OP_SYST;
            lap_pkg::S_SB:    cmd.op = lap_pkg::OP_SB;
            lap_pkg::S_SW:    cmd.op = lap_pkg::OP_SW;
            lap_pkg::S_FBW:   cmd.op = lap_pkg::OP_FBW;
            lap_pkg::S_MIX:   cmd.op = lap_pkg::OP_MIX;
            lap_pkg::S_OUT:   cmd.op = status.out_free ? lap_pkg::OP_OUT : lap_pkg::OP_NOP;
            default:          cmd.op = lap_pkg::OP_NOP;
        endcase
    end

endmodule

>>> hw/rtl/lap_dp.sv
// Datapath: shared multiplier, sine/divider registers, allpass state, output register.
module lap_dp #(
    parameter int MAX_STAGES  = 8,
    parameter int CHANNELS    = 2,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  lap_pkg::cmd_t                 cmd,
    input  lap_pkg::cfg_t                 cfg,
    input  logic signed [SAMPLE_BITS-1:0] sample_in,
    input  logic                          out_ready,
    output lap_pkg::status_t              status,
    output logic                          out_valid,
    output logic [SAMPLE_BITS-1:0]        sample_out,
    output logic                          channel_index
);

    localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int NAP  = MAX_STAGES * CHANNELS;
    localparam int AP_W = (NAP > 1) ? $clog2(NAP) : 1;
    localparam int IDX_W = lap_pkg::STG_W + 4;
    localparam int SMAX = (1 << (SAMPLE_BITS - 1)) - 1;

    logic [31:0]               phase_reg;
    logic [CH_W-1:0]           chan_cnt_reg;
    logic [CH_W-1:0]           ch_reg;
    logic signed [16:0]        alpha_reg;
    logic signed [SAMPLE_BITS-1:0] x_in_reg;
    logic [15:0]               x_reg;
    logic                      neg_reg;
    logic [15:0]               x2_reg;
    logic signed [lap_pkg::PROD_W-1:0] p_reg;
    logic signed [16:0]        sn_reg;
    logic signed [16:0]        cs_reg;
    logic [14:0]               f_reg;
    logic [16:0]               rem_reg;
    logic [30:0]               qn_reg;
    logic                      dsign_reg;
    logic [16:0]               den_reg;
    logic signed [lap_pkg::SIG_W-1:0] v_reg;
    logic signed [lap_pkg::SIG_W-1:0] y_reg;
    logic signed [lap_pkg::SIG_W-1:0] ap_reg [NAP];
    logic signed [lap_pkg::SIG_W-1:0] fb_reg [CHANNELS];
    logic                      out_valid_reg;
    logic [SAMPLE_BITS-1:0]    out_data_reg;
    logic                      out_ch_reg;

    logic [3:0]                nch;
    logic [CH_W-1:0]           ch_now;
    logic [3:0]                ch_inc;
    logic [31:0]               src_ph;
    logic [15:0]               x_fold;
    logic [15:0]               p_mid;
    logic signed [16:0]        y17;
    logic signed [17:0]        s18;
    logic [15:0]               u16;
    logic [15:0]               fsum;
    logic signed [17:0]        diff;
    logic [16:0]               mag;
    logic [17:0]               rem_sh;
    logic                      qbit;
    logic [IDX_W-1:0]          idx_wide;
    logic [AP_W-1:0]           ap_idx;
    logic signed [lap_pkg::MA_W-1:0] ma;
    logic signed [lap_pkg::MB_W-1:0] mb;
    logic signed [lap_pkg::PROD_W-1:0] prod;
    logic                      mul_en;
    logic signed [lap_pkg::RND_W-1:0] r28;
    logic signed [lap_pkg::SIG_W-1:0] y_new;
    logic signed [lap_pkg::SIG_W-1:0] st_new;
    logic signed [lap_pkg::SIG_W-1:0] v_new;
    logic [SAMPLE_BITS-1:0]    mix_sat;

    always_comb
    begin
        if (cfg.channels_used == 2'd0)
            nch = 4'd1;
        else if ({2'b00, cfg.channels_used} > 4'(CHANNELS))
            nch = 4'(CHANNELS);
        else
            nch = {2'b00, cfg.channels_used};
        ch_now = ({{(4 > CH_W ? 4 - CH_W : 0){1'b0}}, chan_cnt_reg} >= nch) ? '0 : chan_cnt_reg;
        ch_inc = 4'(ch_now) + 4'd1;
        status.frame_start = (ch_now == '0);
        status.out_free = !out_valid_reg || out_ready;
    end

    always_comb
    begin
        priority if (cmd.sel == lap_pkg::SEL_LFO)
            src_ph = phase_reg;
        else if (cmd.sel == lap_pkg::SEL_SN)
            src_ph = {2'b00, f_reg, 15'd0};
        else
            src_ph = {2'b01, f_reg, 15'd0};
        x_fold = src_ph[30] ? (16'd32768 - {1'b0, src_ph[29:15]}) : {1'b0, src_ph[29:15]};
        p_mid = p_reg[30:15];
        y17 = neg_reg ? -$signed({1'b0, p_mid}) : $signed({1'b0, p_mid});
        s18 = 18'(y17) + 18'sd32768;
        u16 = s18[16:1];
        fsum = {1'b0, cfg.freq_low} + p_mid;
        diff = 18'(sn_reg) - 18'(cs_reg);
        mag = diff[17] ? 17'(-diff) : 17'(diff);
        rem_sh = {rem_reg, qn_reg[30]};
        qbit = (rem_sh >= {1'b0, den_reg});
        idx_wide = IDX_W'(cmd.stage) * IDX_W'(CHANNELS) + IDX_W'(ch_reg);
        ap_idx = idx_wide[AP_W-1:0];
        r28 = lap_pkg::rnd15(p_reg);
        y_new = lap_pkg::sat24(29'(r28) + 29'(ap_reg[ap_idx]));
        st_new = lap_pkg::sat24(29'(v_reg) - 29'(r28));
        v_new = lap_pkg::sat24(29'(x_in_reg) + 29'(r28));
        if (r28 > $signed(lap_pkg::RND_W'(SMAX)))
            mix_sat = SAMPLE_BITS'(SMAX);
        else if (r28 < -$signed(lap_pkg::RND_W'(SMAX)) - 1)
            mix_sat = SAMPLE_BITS'(-SMAX - 1);
        else
            mix_sat = r28[SAMPLE_BITS-1:0];
    end

    always_comb
    begin
        mul_en = 1'b1;
        ma = '0;
        mb = '0;
        unique case (cmd.op)
            lap_pkg::OP_M1:
            begin
                ma = $signed({9'd0, x_reg});
                mb = $signed({2'd0, x_reg});
            end
            lap_pkg::OP_M2:
            begin
                ma = $signed({9'd0, p_mid});
                mb = $signed({2'd0, lap_pkg::SIN_C});
            end
            lap_pkg::OP_M3:
            begin
                ma = $signed({9'd0, x2_reg});
                mb = $signed({2'd0, lap_pkg::SIN_B - p_mid});
            end
            lap_pkg::OP_M4:
            begin
                ma = $signed({9'd0, x_reg});
                mb = $signed({2'd0, lap_pkg::SIN_A - p_mid});
            end
            lap_pkg::OP_SY:
            begin
                mul_en = (cmd.sel == lap_pkg::SEL_LFO);
                ma = $signed({9'd0, u16});
                mb = $signed({3'd0, cfg.freq_span});
            end
            lap_pkg::OP_FB:
            begin
                ma = lap_pkg::MA_W'(fb_reg[ch_reg]);
                mb = lap_pkg::MB_W'(cfg.feedback_gain);
            end
            lap_pkg::OP_SA:
            begin
                ma = lap_pkg::MA_W'(v_reg);
                mb = lap_pkg::MB_W'(alpha_reg);
            end
            lap_pkg::OP_SB:
            begin
                ma = lap_pkg::MA_W'(y_reg);
                mb = lap_pkg::MB_W'(alpha_reg);
            end
            lap_pkg::OP_FBW:
            begin
                ma = lap_pkg::MA_W'(x_in_reg);
                mb = $signed({2'd0, cfg.dry_gain});
            end
            lap_pkg::OP_MIX:
            begin
                ma = lap_pkg::MA_W'(v_reg);
                mb = $signed({2'd0, cfg.wet_gain});
            end
            default: mul_en = 1'b0;
        endcase
        prod = lap_pkg::PROD_W'(ma) * lap_pkg::PROD_W'(mb);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= '0;
            chan_cnt_reg  <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < NAP; i++)
                ap_reg[i] <= '0;
            for (int i = 0; i < CHANNELS; i++)
                fb_reg[i] <= '0;
        end
        else
        begin
            if (cmd.op == lap_pkg::OP_OUT)
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && out_ready)
                out_valid_reg <= 1'b0;
            unique case (cmd.op)
                lap_pkg::OP_LOAD:
                    chan_cnt_reg <= (ch_inc >= nch) ? '0 : CH_W'(ch_inc);
                lap_pkg::OP_DEND:
                    phase_reg <= phase_reg + cfg.phase_step;
                lap_pkg::OP_SW:
                    ap_reg[ap_idx] <= st_new;
                lap_pkg::OP_FBW:
                    fb_reg[ch_reg] <= v_reg;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (mul_en)
            p_reg <= (cmd.op == lap_pkg::OP_MIX) ? p_reg + prod : prod;
        unique case (cmd.op)
            lap_pkg::OP_LOAD:
            begin
                x_in_reg <= sample_in;
                ch_reg   <= ch_now;
            end
            lap_pkg::OP_SX:
            begin
                x_reg   <= x_fold;
                neg_reg <= src_ph[31];
            end
            lap_pkg::OP_M2:
                x2_reg <= p_mid;
            lap_pkg::OP_SY:
            begin
                if (cmd.sel == lap_pkg::SEL_SN)
                    sn_reg <= y17;
                if (cmd.sel == lap_pkg::SEL_CS)
                    cs_reg <= y17;
            end
            lap_pkg::OP_FREQ:
                f_reg <= (fsum > lap_pkg::FREQ_CLAMP) ? lap_pkg::FREQ_CLAMP[14:0] : fsum[14:0];
            lap_pkg::OP_DINIT:
            begin
                rem_reg   <= '0;
                qn_reg    <= {mag[15:0], 15'd0};
                dsign_reg <= diff[17];
                den_reg   <= 17'(sn_reg + cs_reg);
            end
            lap_pkg::OP_DSTEP:
            begin
                rem_reg <= qbit ? 17'(rem_sh - {1'b0, den_reg}) : rem_sh[16:0];
                qn_reg  <= {qn_reg[29:0], qbit};
            end
            lap_pkg::OP_DEND:
                alpha_reg <= dsign_reg ? -$signed(qn_reg[16:0]) : $signed(qn_reg[16:0]);
            lap_pkg::OP_V:
                v_reg <= v_new;
            lap_pkg::OP_SYST:
                y_reg <= y_new;
            lap_pkg::OP_SW:
                v_reg <= y_reg;
            lap_pkg::OP_OUT:
            begin
                out_data_reg <= mix_sat;
                out_ch_reg   <= ch_reg[0];
            end
            default: ;
        endcase
    end

    assign out_valid     = out_valid_reg;
    assign sample_out    = out_data_reg;
    assign channel_index = out_ch_reg;

endmodule

>>> hw/rtl/lfo_allpass_phaser.sv
// Top level of the LFO-swept allpass phaser: config registers, sequencer, datapath.
//  channel  dir  signals                          payload
//  s_axis   in   s_tvalid s_tready s_tdata        sample_in
//  m_axis   out  m_tvalid m_tready m_tdata m_tuser sample_out, channel_index
//  cfg      in   cfg_valid cfg_ready cfg_addr cfg_data  register write
// The first channel of a frame adds three sine evaluations on the shared multiplier
// and a 31-step divider.
// Reset clears LFO phase, channel count, allpass and feedback state.
// A stalled output holds one result while the next item is already being worked on.
module lfo_allpass_phaser #(
    parameter int MAX_STAGES  = 8,
    parameter int CHANNELS    = 2,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [((SAMPLE_BITS+7)/8)*8-1:0]     s_tdata,   // sample_in
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [((SAMPLE_BITS+7)/8)*8-1:0]     m_tdata,   // sample_out
    output logic                                 m_tuser,   // channel_index
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [2:0]                           cfg_addr,
    input  logic [31:0]                          cfg_data
);

    localparam int TD_W = ((SAMPLE_BITS + 7) / 8) * 8;

    lap_pkg::cfg_t    cfg_reg;
    lap_pkg::cmd_t    cmd;
    lap_pkg::status_t status;
    logic [SAMPLE_BITS-1:0] sample_out;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.phase_step    <= 32'd44739;
            cfg_reg.freq_low      <= 15'd601;
            cfg_reg.freq_span     <= 15'd1584;
            cfg_reg.feedback_gain <= 16'sd16384;
            cfg_reg.wet_gain      <= 16'd16384;
            cfg_reg.dry_gain      <= 16'd16384;
            cfg_reg.stages_used   <= 4'd4;
            cfg_reg.channels_used <= 2'd2;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_addr)
                lap_pkg::REG_PHASE_STEP:    cfg_reg.phase_step    <= cfg_data;
                lap_pkg::REG_FREQ_LOW:      cfg_reg.freq_low      <= cfg_data[14:0];
                lap_pkg::REG_FREQ_SPAN:     cfg_reg.freq_span     <= cfg_data[14:0];
                lap_pkg::REG_FEEDBACK_GAIN: cfg_reg.feedback_gain <= cfg_data[15:0];
                lap_pkg::REG_WET_GAIN:      cfg_reg.wet_gain      <= cfg_data[15:0];
                lap_pkg::REG_DRY_GAIN:      cfg_reg.dry_gain      <= cfg_data[15:0];
                lap_pkg::REG_STAGES_USED:   cfg_reg.stages_used   <= cfg_data[3:0];
                lap_pkg::REG_CHANNELS_USED: cfg_reg.channels_used <= cfg_data[1:0];
                default: ;
            endcase
        end
    end

    lap_ctrl #(
        .MAX_STAGES (MAX_STAGES)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .stages_used (cfg_reg.stages_used),
        .status      (status),
        .cmd         (cmd)
    );

    lap_dp #(
        .MAX_STAGES  (MAX_STAGES),
        .CHANNELS    (CHANNELS),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .cfg           (cfg_reg),
        .sample_in     (s_tdata[SAMPLE_BITS-1:0]),
        .out_ready     (m_tready),
        .status        (status),
        .out_valid     (m_tvalid),
        .sample_out    (sample_out),
        .channel_index (m_tuser)
    );

    assign m_tdata = TD_W'(sample_out);

endmodule
